### rtl/caf_pkg.sv
// ----------------------------------------------------------------------------
// caf_pkg: shared types and operation codes of the ALU with flags
// Request and response beat layouts, and the operation code map.
// ----------------------------------------------------------------------------
package caf_pkg;

    localparam int unsigned OP_W = 6;

    localparam logic [OP_W-1:0] OP_ADD       = 6'd0;
    localparam logic [OP_W-1:0] OP_ADC       = 6'd1;
    localparam logic [OP_W-1:0] OP_SUB       = 6'd2;
    localparam logic [OP_W-1:0] OP_SBC       = 6'd3;
    localparam logic [OP_W-1:0] OP_AND       = 6'd4;
    localparam logic [OP_W-1:0] OP_XOR       = 6'd5;
    localparam logic [OP_W-1:0] OP_OR        = 6'd6;
    localparam logic [OP_W-1:0] OP_CP        = 6'd7;
    localparam logic [OP_W-1:0] OP_INC       = 6'd8;
    localparam logic [OP_W-1:0] OP_DEC       = 6'd9;
    localparam logic [OP_W-1:0] OP_RLC       = 6'd10;
    localparam logic [OP_W-1:0] OP_RRC       = 6'd11;
    localparam logic [OP_W-1:0] OP_RL        = 6'd12;
    localparam logic [OP_W-1:0] OP_RR        = 6'd13;
    localparam logic [OP_W-1:0] OP_SLA       = 6'd14;
    localparam logic [OP_W-1:0] OP_SRA       = 6'd15;
    localparam logic [OP_W-1:0] OP_SWAP      = 6'd16;
    localparam logic [OP_W-1:0] OP_SRL       = 6'd17;
    localparam logic [OP_W-1:0] OP_BIT       = 6'd18;
    localparam logic [OP_W-1:0] OP_RES       = 6'd19;
    localparam logic [OP_W-1:0] OP_SET       = 6'd20;
    localparam logic [OP_W-1:0] OP_RLCA      = 6'd21;
    localparam logic [OP_W-1:0] OP_RRCA      = 6'd22;
    localparam logic [OP_W-1:0] OP_RLA       = 6'd23;
    localparam logic [OP_W-1:0] OP_RRA       = 6'd24;
    localparam logic [OP_W-1:0] OP_DAA       = 6'd25;
    localparam logic [OP_W-1:0] OP_CPL       = 6'd26;
    localparam logic [OP_W-1:0] OP_SCF       = 6'd27;
    localparam logic [OP_W-1:0] OP_CCF       = 6'd28;
    localparam logic [OP_W-1:0] OP_ADD16     = 6'd29;
    localparam logic [OP_W-1:0] OP_SP_OFFSET = 6'd30;
    localparam logic [OP_W-1:0] OP_INC16     = 6'd31;
    localparam logic [OP_W-1:0] OP_DEC16     = 6'd32;

    localparam logic [7:0] DAA_LIMIT   = 8'h99;
    localparam logic [7:0] DAA_CORR_HI = 8'h60;
    localparam logic [7:0] DAA_CORR_LO = 8'h06;
    localparam logic [3:0] NIBBLE_MAX  = 4'hF;
    localparam logic [3:0] DIGIT_MAX   = 4'h9;

    typedef struct packed {
        logic [OP_W-1:0] req_type;
        logic [15:0]     target_operand;
        logic [15:0]     source_operand;
        logic [2:0]      bit_index;
        logic            zero_in;
        logic            subtract_in;
        logic            half_carry_in;
        logic            carry_in;
    } req_t;

    typedef struct packed {
        logic [15:0] result_value;
        logic        result_written;
        logic        zero_out;
        logic        subtract_out;
        logic        half_carry_out;
        logic        carry_out;
    } rsp_t;

endpackage

### rtl/caf_req_if.sv
// ----------------------------------------------------------------------------
// caf_req_if: request channel
// Valid/ready channel carrying one operation request per beat.
// ----------------------------------------------------------------------------
interface caf_req_if;
    import caf_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/caf_rsp_if.sv
// ----------------------------------------------------------------------------
// caf_rsp_if: response channel
// Valid/ready channel carrying one result and its flags per beat.
// ----------------------------------------------------------------------------
interface caf_rsp_if;
    import caf_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/caf_alu.sv
// ----------------------------------------------------------------------------
// caf_alu: operation datapath
// Decodes the operation and forms the result, write-back enable and flags.
// ----------------------------------------------------------------------------
module caf_alu
(
    input  caf_pkg::req_t req_data,
    output caf_pkg::rsp_t rsp_data
);
    import caf_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        k_add;
    logic        k_sub;
    logic [8:0]  add9;
    logic [4:0]  addh;
    logic [8:0]  sub9;
    logic [4:0]  subh;
    logic [16:0] add17;
    logic [12:0] add13;
    logic [8:0]  spl9;
    logic [4:0]  splh;
    logic [15:0] sp_sum;
    logic [7:0]  bit_mask;
    logic [7:0]  daa_corr;
    logic        daa_c;
    logic [7:0]  daa_res;

    assign a = req_data.target_operand[7:0];
    assign b = req_data.source_operand[7:0];

    assign k_add = (req_data.req_type == OP_ADC) & req_data.carry_in;
    assign k_sub = (req_data.req_type == OP_SBC) & req_data.carry_in;

    assign add9 = {1'b0, a} + {1'b0, b} + {8'd0, k_add};
    assign addh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k_add};
    // bit 8 / bit 4 of the difference is the borrow
    assign sub9 = {1'b0, a} - {1'b0, b} - {8'd0, k_sub};
    assign subh = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, k_sub};

    assign add17 = {1'b0, req_data.target_operand} + {1'b0, req_data.source_operand};
    assign add13 = {1'b0, req_data.target_operand[11:0]}
                 + {1'b0, req_data.source_operand[11:0]};

    // carries from the unsigned low byte, result from the signed offset
    assign spl9   = {1'b0, a} + {1'b0, b};
    assign splh   = {1'b0, a[3:0]} + {1'b0, b[3:0]};
    assign sp_sum = req_data.target_operand + {{8{b[7]}}, b};

    assign bit_mask = 8'd1 << req_data.bit_index;

    always_comb
    begin
        daa_corr = 8'd0;
        daa_c    = req_data.carry_in;
        if (req_data.carry_in || (!req_data.subtract_in && (a > DAA_LIMIT)))
        begin
            daa_corr = daa_corr | DAA_CORR_HI;
            daa_c    = 1'b1;
        end
        if (req_data.half_carry_in || (!req_data.subtract_in && (a[3:0] > DIGIT_MAX)))
        begin
            daa_corr = daa_corr | DAA_CORR_LO;
        end
        daa_res = req_data.subtract_in ? (a - daa_corr) : (a + daa_corr);
    end

    always_comb
    begin
        logic [7:0] r8;
        logic       byte_z;

        r8     = 8'd0;
        byte_z = 1'b0;

        rsp_data.result_value   = req_data.target_operand;
        rsp_data.result_written = 1'b1;
        rsp_data.zero_out       = req_data.zero_in;
        rsp_data.subtract_out   = req_data.subtract_in;
        rsp_data.half_carry_out = req_data.half_carry_in;
        rsp_data.carry_out      = req_data.carry_in;

        unique case (req_data.req_type) inside
            OP_ADD, OP_ADC:
            begin
                r8 = add9[7:0];
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = addh[4];
                rsp_data.carry_out      = add9[8];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                r8 = sub9[7:0];
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b1;
                rsp_data.half_carry_out = subh[4];
                rsp_data.carry_out      = sub9[8];
                rsp_data.result_written = (req_data.req_type != OP_CP);
            end
            OP_AND:
            begin
                r8 = a & b;
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b1;
                rsp_data.carry_out      = 1'b0;
            end
            OP_XOR, OP_OR:
            begin
                r8 = (req_data.req_type == OP_XOR) ? (a ^ b) : (a | b);
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = 1'b0;
            end
            OP_INC:
            begin
                r8 = a + 8'd1;
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = (a[3:0] == NIBBLE_MAX);
            end
            OP_DEC:
            begin
                r8 = a - 8'd1;
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b1;
                rsp_data.half_carry_out = (a[3:0] == 4'd0);
            end
            OP_RLC, OP_RLCA:
            begin
                r8 = {a[6:0], a[7]};
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = a[7];
            end
            OP_RRC, OP_RRCA:
            begin
                r8 = {a[0], a[7:1]};
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = a[0];
            end
            OP_RL, OP_RLA:
            begin
                r8 = {a[6:0], req_data.carry_in};
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = a[7];
            end
            OP_RR, OP_RRA:
            begin
                r8 = {req_data.carry_in, a[7:1]};
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = a[0];
            end
            OP_SLA:
            begin
                r8 = {a[6:0], 1'b0};
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = a[7];
            end
            OP_SRA:
            begin
                r8 = {a[7], a[7:1]};
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = a[0];
            end
            OP_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = 1'b0;
            end
            OP_SRL:
            begin
                r8 = {1'b0, a[7:1]};
                byte_z = 1'b1;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = a[0];
            end
            OP_BIT:
            begin
                r8 = a;
                rsp_data.result_written = 1'b0;
                rsp_data.zero_out       = ~|(a & bit_mask);
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b1;
            end
            OP_RES:
            begin
                r8 = a & ~bit_mask;
            end
            OP_SET:
            begin
                r8 = a | bit_mask;
            end
            OP_DAA:
            begin
                r8 = daa_res;
                byte_z = 1'b1;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = daa_c;
            end
            OP_CPL:
            begin
                r8 = ~a;
                rsp_data.subtract_out   = 1'b1;
                rsp_data.half_carry_out = 1'b1;
            end
            OP_SCF, OP_CCF:
            begin
                r8 = a;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = 1'b0;
                rsp_data.carry_out      = (req_data.req_type == OP_SCF) ? 1'b1
                                                                       : ~req_data.carry_in;
            end
            default:
            begin
            end
        endcase

        // byte operations clear the upper byte; word codes set it below, unused codes keep the target's
        if (req_data.req_type <= OP_CCF)
        begin
            rsp_data.result_value = {8'd0, r8};
        end
        if (byte_z)
        begin
            rsp_data.zero_out = (r8 == 8'd0);
        end

        // accumulator rotates always clear zero
        if ((req_data.req_type == OP_RLCA) || (req_data.req_type == OP_RRCA)
            || (req_data.req_type == OP_RLA) || (req_data.req_type == OP_RRA))
        begin
            rsp_data.zero_out = 1'b0;
        end

        unique case (req_data.req_type) inside
            OP_ADD16:
            begin
                rsp_data.result_value   = add17[15:0];
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = add13[12];
                rsp_data.carry_out      = add17[16];
            end
            OP_SP_OFFSET:
            begin
                rsp_data.result_value   = sp_sum;
                rsp_data.zero_out       = 1'b0;
                rsp_data.subtract_out   = 1'b0;
                rsp_data.half_carry_out = splh[4];
                rsp_data.carry_out      = spl9[8];
            end
            OP_INC16:
            begin
                rsp_data.result_value = req_data.target_operand + 16'd1;
            end
            OP_DEC16:
            begin
                rsp_data.result_value = req_data.target_operand - 16'd1;
            end
            default:
            begin
                if (req_data.req_type > OP_DEC16)
                begin
                    rsp_data.result_written = 1'b0;
                end
            end
        endcase
    end
endmodule

### rtl/cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flags: 8/16-bit ALU with Z N H C flags
// Input register, operation datapath and result register.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per beat: code, target and source operands,
//   bit index and the incoming flags. rsp returns one beat per request with
//   the result, the write-back enable and the new flags, in request order.
//   A request passes through the input register, which loads on the request
//   beat, then the decode and arithmetic, then the result register; rsp is
//   valid once the result register holds the result.
//   Throughput is one operation per cycle; both register stages advance
//   together whenever the result register is empty or being taken.
//   When rsp is stalled the result register holds, the input register
//   still fills if empty, and req.ready drops once both stages are full.
//   Reset clears both stage valid flags; no response is pending afterwards.
//   The block keeps no state between operations.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags
(
    input  logic            clk,
    input  logic            rst_n,
    caf_req_if.sink         req,
    caf_rsp_if.source       rsp
);
    import caf_pkg::*;

    logic s1_valid_reg;
    req_t s1_data_reg;
    logic s2_valid_reg;
    rsp_t s2_data_reg;
    rsp_t alu_rsp;
    logic s1_ready;
    logic s2_ready;

    assign s2_ready = !s2_valid_reg || rsp.ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign req.ready = s1_ready;
    assign rsp.valid = s2_valid_reg;
    assign rsp.data  = s2_data_reg;

    caf_alu u_alu
    (
        .req_data (s1_data_reg),
        .rsp_data (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload holds unless a new beat moves in
    always_ff @(posedge clk)
    begin
        if (req.valid && s1_ready)
        begin
            s1_data_reg <= req.data;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= alu_rsp;
        end
    end
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ALU with flags
// Drives operation requests in random bursts, stalls the result channel on
// its own pattern, and compares every result beat with a predicted value.
// ----------------------------------------------------------------------------
module testbench;
    import caf_pkg::*;

    localparam int unsigned RANDOM_OPS     = 1000;
    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLDOFF_AFTER  = 150;
    localparam int unsigned HOLDOFF_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    caf_req_if req_ch ();
    caf_rsp_if rsp_ch ();

    cpu_alu_with_flags dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    req_t        pending_ops[$];
    rsp_t        expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    always #5 clk = ~clk;

    // Flags are packed as {zero, subtract, half carry, carry}.
    function automatic req_t make_op(logic [OP_W-1:0] op, logic [15:0] t, logic [15:0] s,
                                     logic [2:0] bi, logic [3:0] flags);
        req_t rq;
        rq.req_type       = op;
        rq.target_operand = t;
        rq.source_operand = s;
        rq.bit_index      = bi;
        rq.zero_in        = flags[3];
        rq.subtract_in    = flags[2];
        rq.half_carry_in  = flags[1];
        rq.carry_in       = flags[0];
        return rq;
    endfunction

    function automatic logic [15:0] pick_operand();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 9))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w = {w[15:8], 8'hFF};
            3: w = {w[15:4], 4'hF};
            4: w = {w[15:8], 8'h99};
            5: w = {w[15:12], 12'hFFF};
            6: w = {w[15:8], 8'h00};
            default: ;
        endcase
        return w;
    endfunction

    function automatic rsp_t alu_predict(req_t rq);
        logic [15:0] t;
        logic [15:0] s;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  res8;
        logic [15:0] res16;
        logic [7:0]  corr;
        logic [4:0]  nib;
        logic [8:0]  sum9;
        logic [12:0] sum13;
        logic [16:0] sum17;
        logic        z, n, h, c, cin, k, wr, word_res;
        rsp_t        r;

        t        = rq.target_operand;
        s        = rq.source_operand;
        a        = t[7:0];
        b        = s[7:0];
        z        = rq.zero_in;
        n        = rq.subtract_in;
        h        = rq.half_carry_in;
        c        = rq.carry_in;
        cin      = rq.carry_in;
        wr       = 1'b1;
        word_res = 1'b0;
        res8     = a;
        res16    = t;

        case (rq.req_type)
            OP_ADD, OP_ADC:
            begin
                k    = (rq.req_type == OP_ADC) ? cin : 1'b0;
                nib  = {1'b0, a[3:0]} + b[3:0] + k;
                sum9 = {1'b0, a} + b + k;
                n    = 1'b0;
                h    = nib[4];
                c    = sum9[8];
                res8 = sum9[7:0];
                z    = ~|res8;
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                k    = (rq.req_type == OP_SBC) ? cin : 1'b0;
                n    = 1'b1;
                h    = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + k);
                c    = {1'b0, a} < ({1'b0, b} + k);
                res8 = a - b - k;
                z    = ~|res8;
                if (rq.req_type == OP_CP)
                    wr = 1'b0;
            end
            OP_AND:
            begin
                res8 = a & b;
                z = ~|res8; n = 1'b0; h = 1'b1; c = 1'b0;
            end
            OP_XOR:
            begin
                res8 = a ^ b;
                z = ~|res8; n = 1'b0; h = 1'b0; c = 1'b0;
            end
            OP_OR:
            begin
                res8 = a | b;
                z = ~|res8; n = 1'b0; h = 1'b0; c = 1'b0;
            end
            OP_INC:
            begin
                n    = 1'b0;
                h    = (a[3:0] == NIBBLE_MAX);
                res8 = a + 8'd1;
                z    = ~|res8;
            end
            OP_DEC:
            begin
                n    = 1'b1;
                h    = (a[3:0] == 4'h0);
                res8 = a - 8'd1;
                z    = ~|res8;
            end
            OP_RLC, OP_RLCA:
            begin
                c = a[7]; res8 = {a[6:0], a[7]};
                z = (rq.req_type == OP_RLCA) ? 1'b0 : ~|res8; n = 1'b0; h = 1'b0;
            end
            OP_RRC, OP_RRCA:
            begin
                c = a[0]; res8 = {a[0], a[7:1]};
                z = (rq.req_type == OP_RRCA) ? 1'b0 : ~|res8; n = 1'b0; h = 1'b0;
            end
            OP_RL, OP_RLA:
            begin
                c = a[7]; res8 = {a[6:0], cin};
                z = (rq.req_type == OP_RLA) ? 1'b0 : ~|res8; n = 1'b0; h = 1'b0;
            end
            OP_RR, OP_RRA:
            begin
                c = a[0]; res8 = {cin, a[7:1]};
                z = (rq.req_type == OP_RRA) ? 1'b0 : ~|res8; n = 1'b0; h = 1'b0;
            end
            OP_SLA:
            begin
                c = a[7]; res8 = {a[6:0], 1'b0};
                z = ~|res8; n = 1'b0; h = 1'b0;
            end
            OP_SRA:
            begin
                c = a[0]; res8 = {a[7], a[7:1]};
                z = ~|res8; n = 1'b0; h = 1'b0;
            end
            OP_SWAP:
            begin
                res8 = {a[3:0], a[7:4]};
                z = ~|res8; n = 1'b0; h = 1'b0; c = 1'b0;
            end
            OP_SRL:
            begin
                c = a[0]; res8 = {1'b0, a[7:1]};
                z = ~|res8; n = 1'b0; h = 1'b0;
            end
            OP_BIT:
            begin
                wr = 1'b0;
                z  = ~a[rq.bit_index];
                n  = 1'b0;
                h  = 1'b1;
            end
            OP_RES: res8 = a & ~(8'h01 << rq.bit_index);
            OP_SET: res8 = a | (8'h01 << rq.bit_index);
            OP_DAA:
            begin
                corr = 8'h00;
                if (c || (!n && a > DAA_LIMIT))
                begin
                    corr = corr | DAA_CORR_HI;
                    c    = 1'b1;
                end
                if (h || (!n && a[3:0] > DIGIT_MAX))
                    corr = corr | DAA_CORR_LO;
                res8 = n ? (a - corr) : (a + corr);
                z    = ~|res8;
                h    = 1'b0;
            end
            OP_CPL:
            begin
                res8 = ~a; n = 1'b1; h = 1'b1;
            end
            OP_SCF:
            begin
                n = 1'b0; h = 1'b0; c = 1'b1;
            end
            OP_CCF:
            begin
                n = 1'b0; h = 1'b0; c = ~cin;
            end
            OP_ADD16:
            begin
                word_res = 1'b1;
                sum13    = {1'b0, t[11:0]} + s[11:0];
                sum17    = {1'b0, t} + s;
                n        = 1'b0;
                h        = sum13[12];
                c        = sum17[16];
                res16    = sum17[15:0];
            end
            OP_SP_OFFSET:
            begin
                word_res = 1'b1;
                nib      = {1'b0, t[3:0]} + b[3:0];
                sum9     = {1'b0, t[7:0]} + b;
                z        = 1'b0;
                n        = 1'b0;
                h        = nib[4];
                c        = sum9[8];
                res16    = t + {{8{b[7]}}, b};
            end
            OP_INC16:
            begin
                word_res = 1'b1;
                res16    = t + 16'd1;
            end
            OP_DEC16:
            begin
                word_res = 1'b1;
                res16    = t - 16'd1;
            end
            default:
            begin
                // Unused codes: target passes through untouched
                word_res = 1'b1;
                wr       = 1'b0;
            end
        endcase

        r.result_value   = word_res ? res16 : {8'h00, res8};
        r.result_written = wr;
        r.zero_out       = z;
        r.subtract_out   = n;
        r.half_carry_out = h;
        r.carry_out      = c;
        return r;
    endfunction

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        logic [OP_W-1:0] op;
        logic [15:0]     t;
        logic [15:0]     s;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;

        // Every defined operation with the operands at their extremes
        for (int i = 0; i <= int'(OP_DEC16); i++)
        begin
            if (i % 2 == 0)
                pending_ops.push_back(make_op(OP_W'(i), 16'hFFFF, 16'h0001, 3'd7, 4'hF));
            else
                pending_ops.push_back(make_op(OP_W'(i), 16'h0000, 16'hFFFF, 3'd0, 4'h0));
        end
        pending_ops.push_back(make_op(OP_ADD, 16'h000F, 16'h0001, 3'd0, 4'h0));
        pending_ops.push_back(make_op(OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0));
        pending_ops.push_back(make_op(OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'h7));
        pending_ops.push_back(make_op(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'hF));
        pending_ops.push_back(make_op(OP_SP_OFFSET, 16'h00FF, 16'h0080, 3'd0, 4'hF));
        pending_ops.push_back(make_op(OP_CP, 16'hAB12, 16'hCD12, 3'd0, 4'h0));
        pending_ops.push_back(make_op(OP_W'(33), 16'h5AA5, 16'h1234, 3'd3, 4'hA));
        pending_ops.push_back(make_op(OP_W'(63), 16'hA55A, 16'hFFFF, 3'd4, 4'h5));

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            // Mostly defined codes, an occasional unused one
            if ($urandom_range(0, 19) == 0)
                op = OP_W'($urandom_range(33, 63));
            else
                op = OP_W'($urandom_range(0, int'(OP_DEC16)));
            t = pick_operand();
            s = pick_operand();
            pending_ops.push_back(make_op(op, t, s, 3'($urandom_range(0, 7)),
                                          4'($urandom_range(0, 15))));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Request driver: bursts of random length separated by random gaps
    always @(posedge clk)
    begin : req_driver
        int unsigned burst_left;
        int unsigned gap_left;

        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(alu_predict(pending_ops.pop_front()));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end

            // Hold an offered beat until it is taken
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_ops[0];
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall pattern of its own plus one long hold-off
    always @(posedge clk)
    begin : rsp_receiver
        int unsigned results_taken;
        int unsigned hold_left;
        bit          holdoff_done;
        int unsigned rx_phase;
        int unsigned rx_mode;

        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                results_taken++;
            if (!holdoff_done && results_taken >= HOLDOFF_AFTER)
            begin
                hold_left    = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rx_phase++;
                if (rx_phase % 64 == 0)
                    rx_mode = $urandom_range(0, 2);
                case (rx_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result checker and watchdog
    always @(posedge clk)
    begin : rsp_checker
        rsp_t want;

        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, rsp_ch.data);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("result_value", want.result_value,
                                  rsp_ch.data.result_value);
                    compare_field("result_written", 16'(want.result_written),
                                  16'(rsp_ch.data.result_written));
                    compare_field("zero_out", 16'(want.zero_out),
                                  16'(rsp_ch.data.zero_out));
                    compare_field("subtract_out", 16'(want.subtract_out),
                                  16'(rsp_ch.data.subtract_out));
                    compare_field("half_carry_out", 16'(want.half_carry_out),
                                  16'(rsp_ch.data.half_carry_out));
                    compare_field("carry_out", 16'(want.carry_out),
                                  16'(rsp_ch.data.carry_out));
                end
            end

            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
